### rtl/axis_autorange_deadzone_assert.svh
// Assertion macros for the port-level checker of the axis conditioner.
`ifndef AXIS_AUTORANGE_DEADZONE_ASSERT_SVH
`define AXIS_AUTORANGE_DEADZONE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define AADZ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("axis conditioner check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define AADZ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("axis conditioner check failed");

`endif

### rtl/aadz_pkg.sv
// Shared widths, reset values and constants of the axis conditioner.
package aadz_pkg;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 18;
  localparam int PEAK_W   = 16;
  localparam int DZ_W     = 16;
  // quotient spans 0..65536
  localparam int Q_W      = 17;
  // divider operands: numerator and divisor both stay at or below 2^31
  localparam int DIV_W    = 32;
  // shared multiplier: 16-bit peak times 17-bit factor
  localparam int MUL_W    = PEAK_W + DZ_W + 1;

  localparam int NUM_CHANNELS_DEF = 8;

  localparam logic [PEAK_W-1:0] PEAK_RESET = 16'd16384;
  localparam logic [DZ_W-1:0]   DZ_RESET   = 16'd6554;
  localparam logic [DZ_W:0]     ONE_Q16    = 17'h10000;

endpackage

### rtl/aadz_peak_store.sv
// Per-channel peak magnitude store with valid bits standing in for reset.
module aadz_peak_store import aadz_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [PEAK_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [PEAK_W-1:0] wr_data
);

  logic [PEAK_W-1:0]       mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;
  logic [PEAK_W-1:0]       mem_q_r;
  logic                    vld_q_r;

  // valid bits: cleared by reset, set on first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // storage array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      vld_q_r <= vld_r[rd_addr];
    end
  end

  // unwritten entries read as the reset peak
  assign rd_data = vld_q_r ? mem_q_r : PEAK_RESET;

endmodule

### rtl/aadz_divider.sv
// Restoring divider, one quotient bit per cycle, quotient of Q_W bits.
module aadz_divider import aadz_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DIV_W:0]   rem_r;
  logic [DIV_W-1:0] den_r;
  logic [Q_W-1:0]   quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic             ge;
  logic [DIV_W:0]   sub;
  logic [DIV_W:0]   rem_sel;
  logic [DIV_W:0]   rem_nxt;

  // one trial subtraction per step; remainder stays below the divisor
  always_comb begin
    ge      = rem_r >= {1'b0, den_r};
    sub     = rem_r - {1'b0, den_r};
    rem_sel = ge ? sub : rem_r;
    rem_nxt = {rem_sel[DIV_W-1:0], 1'b0};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend};
      den_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[Q_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### rtl/axis_autorange_deadzone.sv
// Axis conditioner: per-channel peak tracking, dead zone and rescale to Q16.
// Path from accept to out_valid: S_READ, S_MUL1, S_MUL2, S_DIV (17-step serial divide),
//   S_OUT; in the dead zone S_MUL2 goes straight to S_OUT. One item at a time: in_ready
//   only while idle, and a new result waits in S_OUT while the previous one is not yet taken.
// Reset (rst_n, synchronous, active low): dead zone back to 6554, every
//   channel's peak reads 16384 again at once through cleared valid bits.
module axis_autorange_deadzone import aadz_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [DZ_W-1:0]           cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CHAN_W-1:0]         in_channel,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [PEAK_W-1:0]         out_peak
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int RED_W = 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state_r;
  logic [DZ_W-1:0]     dz_r;
  logic [IDX_W-1:0]    idx_r;
  logic                neg_r;
  logic [PEAK_W-1:0]   mag_r;
  logic [PEAK_W-1:0]   pk_r;
  logic [DIV_W-1:0]    thr_r;
  logic [Q_W-1:0]      q_r;
  logic                out_valid_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [PEAK_W-1:0]   out_peak_r;

  logic [RED_W-1:0]    red;
  logic [IDX_W-1:0]    in_idx;
  logic                in_neg;
  logic [PEAK_W-1:0]   in_mag;
  logic                accept;
  logic [PEAK_W-1:0]   trk_rd_data;
  logic [PEAK_W-1:0]   pk_nxt;
  logic [DZ_W:0]       mul_b;
  logic [MUL_W-1:0]    product;
  logic [DIV_W-1:0]    lhs;
  logic                below_dz;
  logic [DIV_W-1:0]    diff;
  logic                div_start;
  logic                div_done;
  logic [Q_W-1:0]      div_quot;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // channel modulo channel count: a few compare-subtract steps on a 3-bit value
  always_comb begin
    red = {{(RED_W - CHAN_W){1'b0}}, in_channel};
    for (int i = 0; i < 8; i++) begin
      if (red >= RED_W'(NUM_CHANNELS)) begin
        red = red - RED_W'(NUM_CHANNELS);
      end
    end
    in_idx = red[IDX_W-1:0];
  end

  // sample magnitude; -32768 gives 32768
  assign in_neg = in_sample[SAMPLE_W-1];
  assign in_mag = in_neg ? PEAK_W'(-in_sample) : PEAK_W'(in_sample);

  // peak update: zero treated as one, grows to the magnitude
  always_comb begin
    pk_nxt = (trk_rd_data == '0) ? PEAK_W'(1) : trk_rd_data;
    if (mag_r > pk_nxt) begin
      pk_nxt = mag_r;
    end
  end

  // shared multiplier: peak * dead zone, then peak * (1 - dead zone)
  assign mul_b   = (state_r == S_MUL1) ? {1'b0, dz_r} : (ONE_Q16 - {1'b0, dz_r});
  assign product = {{(MUL_W - PEAK_W){1'b0}}, pk_r} * {{(MUL_W - DZ_W - 1){1'b0}}, mul_b};

  // dead zone test and numerator
  assign lhs       = {mag_r, {(DIV_W - PEAK_W){1'b0}}};
  assign below_dz  = lhs < thr_r;
  assign diff      = lhs - thr_r;
  assign div_start = (state_r == S_MUL2) && !below_dz;

  aadz_peak_store #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (trk_rd_data),
    .wr_en   (state_r == S_READ),
    .wr_addr (idx_r),
    .wr_data (pk_nxt)
  );

  aadz_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  (product[DIV_W-1:0]),
    .done     (div_done),
    .quot     (div_quot)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else if (cfg_wr_en) begin
      dz_r <= cfg_wr_data;
    end
  end

  // sequencer with registered output item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; S_OUT handles its own reload
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r   <= in_idx;
            neg_r   <= in_neg;
            mag_r   <= in_mag;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          pk_r    <= pk_nxt;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          thr_r   <= product[DIV_W-1:0];
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          if (below_dz) begin
            q_r     <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            q_r     <= div_quot;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= neg_r ? VALUE_W'(-{1'b0, q_r}) : VALUE_W'({1'b0, q_r});
            out_peak_r  <= pk_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_peak  = out_peak_r;

endmodule

### rtl/aadz_checker.sv
// Port-level checks of the axis conditioner, bound to the top level.
`include "axis_autorange_deadzone_assert.svh"

module aadz_checker import aadz_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [VALUE_W-1:0]  out_value,
  input logic [PEAK_W-1:0]          out_peak
);

  // a stalled result item holds
  `AADZ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_peak))

  // one item at a time: busy right after an accept
  `AADZ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // tracked peak stays within 1..32768
  `AADZ_ASSERT_NOW(a_peak_range, out_valid, (out_peak != '0) && (out_peak <= 16'd32768))

  // conditioned value within full scale
  `AADZ_ASSERT_NOW(a_value_range, out_valid, (out_value <= 18'sd65536) && (out_value >= -18'sd65536))

endmodule

bind axis_autorange_deadzone aadz_checker u_aadz_checker (.*);

### tb/sv/axis_cond_checker.sv
// Checker for the axis conditioner: watches both channels, predicts and compares each result.
module axis_cond_checker import aadz_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [DZ_W-1:0]            cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [CHAN_W-1:0]          in_channel,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [VALUE_W-1:0]  out_value,
  input  logic [PEAK_W-1:0]          out_peak,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CHAN_W-1:0]          ch;
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [VALUE_W-1:0]  value;
    logic [PEAK_W-1:0]          peak;
  } axis_result_t;

  // model copy of the block's state
  logic [PEAK_W-1:0] peak_track [NUM_CHANNELS];
  logic [DZ_W-1:0]   dz_model;

  axis_result_t expected_axis [$];
  int n_bad;
  int n_checked;

  // peak update, dead zone test and Q16 rescale for one sample
  function automatic axis_result_t condition_sample(input logic [CHAN_W-1:0] ch,
                                                    input logic signed [SAMPLE_W-1:0] smp);
    axis_result_t r;
    logic [SAMPLE_W-1:0] raw;
    logic [16:0] mag;
    logic [16:0] pk;
    logic [63:0] lhs;
    logic [63:0] thr;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    int idx;
    idx = int'(ch) % NUM_CHANNELS;
    raw = smp;
    mag = raw[SAMPLE_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    pk = {1'b0, peak_track[idx]};
    if (pk == 17'd0) pk = 17'd1;
    if (mag > pk) pk = mag;
    peak_track[idx] = pk[PEAK_W-1:0];
    lhs = 64'(mag) << 16;
    thr = 64'(dz_model) * 64'(pk);
    if (lhs < thr) begin
      q = 64'd0;
    end else begin
      num = (lhs - thr) << 16;
      den = 64'(pk) * (64'(ONE_Q16) - 64'(dz_model));
      q = num / den;
    end
    if (q > 64'(ONE_Q16)) q = 64'(ONE_Q16);
    r.ch = ch;
    r.smp = smp;
    r.value = VALUE_W'(raw[SAMPLE_W-1] ? (64'd0 - q) : q);
    r.peak = pk[PEAK_W-1:0];
    return r;
  endfunction

  // sample both channels on the clock edge; results checked before new items queued
  always @(posedge clk) begin
    axis_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) peak_track[i] = PEAK_RESET;
      dz_model = DZ_RESET;
      expected_axis.delete();
    end else begin
      if (cfg_wr_en) dz_model = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_axis.size() == 0) begin
          n_bad++;
          $display("%0t: result with nothing pending: value %0d peak %0d",
                   $time, out_value, out_peak);
        end else begin
          want = expected_axis.pop_front();
          n_checked++;
          if (out_value !== want.value) begin
            n_bad++;
            $display("%0t: ch %0d sample %0d: value expected %0d, got %0d",
                     $time, want.ch, want.smp, want.value, out_value);
          end
          if (out_peak !== want.peak) begin
            n_bad++;
            $display("%0t: ch %0d sample %0d: peak expected %0d, got %0d",
                     $time, want.ch, want.smp, want.peak, out_peak);
          end
        end
      end
      if (in_valid && in_ready) expected_axis.push_back(condition_sample(in_channel, in_sample));
    end
    pending    <= expected_axis.size();
    fail_count <= n_bad;
    checked    <= n_checked;
  end

endmodule

### tb/sv/tb.sv
// Testbench top for the axis conditioner: clock, reset, stimulus, receiver stalls and verdict.
module tb import aadz_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 123;
  localparam int LONG_STALL      = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int END_CYCLES      = 40;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [DZ_W-1:0]            cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [CHAN_W-1:0]          in_channel;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [VALUE_W-1:0]  out_value;
  logic [PEAK_W-1:0]          out_peak;

  int fail_count;
  int pending;
  int checked;

  int   n_sent;
  int   n_cfg;
  int   idle_cycles;
  logic tx_idle_en;
  logic rx_idle_en;
  logic long_stall_req;

  axis_autorange_deadzone #(.NUM_CHANNELS(NUM_CHANNELS_DEF)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_channel  (in_channel),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .out_peak    (out_peak)
  );

  axis_cond_checker #(.NUM_CHANNELS(NUM_CHANNELS_DEF)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_channel  (in_channel),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .out_peak    (out_peak),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog: too long without any item moving on either channel
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: short random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one item, with an optional idle burst ahead of it
  task automatic offer_sample(input logic [CHAN_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_channel <= ch;
    in_sample  <= smp;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // dead zone write once every result is back and the block is idle
  task automatic set_dead_zone(input logic [DZ_W-1:0] dz);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_cfg++;
  endtask

  // random sample: mostly within the phase's magnitude bound, some near the
  // dead zone edge, some near the bound, some raw or extreme codes
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int bound,
                                                             input logic [DZ_W-1:0] dz);
    int   mag;
    logic neg;
    neg = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: mag = $urandom_range(0, bound);
      4, 5: mag = int'((longint'(dz) * bound) >>> 16) + $urandom_range(0, 8) - 4;
      6: mag = bound - $urandom_range(0, 3);
      7: return SAMPLE_W'($urandom);
      8: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: mag = $urandom_range(0, 255);
    endcase
    if (mag < 0) mag = 0;
    if (neg) begin
      if (mag > 32768) mag = 32768;
      return SAMPLE_W'(-mag);
    end
    if (mag > 32767) mag = 32767;
    return SAMPLE_W'(mag);
  endfunction

  // main stimulus
  initial begin
    logic [DZ_W-1:0] dz;
    int bound;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_channel     = '0;
    in_sample      = '0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    long_stall_req = 1'b0;
    n_sent         = 0;
    n_cfg          = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, default dead zone: reset peaks, peak at full scale, growth
    offer_sample(3'd0, 16'sd0);
    offer_sample(3'd0, 16'sd16384);
    offer_sample(3'd0, -16'sd16384);
    offer_sample(3'd1, 16'sd32767);
    offer_sample(3'd1, 16'sh8000);
    offer_sample(3'd2, 16'sh8000);
    offer_sample(3'd2, 16'sd1);
    offer_sample(3'd2, -16'sd1);
    offer_sample(3'd3, 16'sd1000);
    offer_sample(3'd3, 16'sd1638);
    offer_sample(3'd3, -16'sd1639);
    offer_sample(3'd4, 16'sd20000);
    offer_sample(3'd5, -16'sd12000);
    offer_sample(3'd6, 16'sd16385);
    offer_sample(3'd7, -16'sd8192);

    // zero dead zone, zero sample gives zero
    set_dead_zone(16'd0);
    offer_sample(3'd5, 16'sd0);
    offer_sample(3'd5, 16'sd100);
    offer_sample(3'd6, 16'sh8000);

    // widest dead zone: only a sample at the peak escapes it
    set_dead_zone(16'hffff);
    offer_sample(3'd7, 16'sd16384);
    offer_sample(3'd7, 16'sd16383);
    offer_sample(3'd7, -16'sd16384);
    offer_sample(3'd4, -16'sd20000);

    // random phases: each with its own dead zone and a growing magnitude bound
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: dz = 16'd1;
        1: dz = 16'd32768;
        2: dz = 16'hfffe;
        3: dz = 16'hffff;
        4: dz = 16'd0;
        N_PHASES - 1: dz = DZ_RESET;
        default: dz = DZ_W'($urandom);
      endcase
      set_dead_zone(dz);
      tx_idle_en = (p != N_PHASES - 1) && (p % 3 != 2);
      rx_idle_en = tx_idle_en;
      if (p == 1) long_stall_req = 1'b1;
      bound = 16384 + (p * 16384) / (N_PHASES - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        offer_sample(CHAN_W'($urandom_range(0, 7)), pick_sample(bound, dz));
    end

    // drain, then watch for stray results
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (END_CYCLES) @(posedge clk);

    $display("tb: %0d samples on all %0d channels, %0d results compared, %0d dead zone writes",
             n_sent, NUM_CHANNELS_DEF, checked, n_cfg);
    $display("tb: dead zone swept from 0 to 65535, peaks grown from reset up to full scale");
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
